>>> rtl/core/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the shared/exclusive lock table.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Table sizes; both must be powers of two.
  localparam int ITEM_COUNT = 1024;
  localparam int TX_COUNT   = 256;

  localparam int OP_W   = 1;
  localparam int TID_W  = 8;
  localparam int ITEM_W = 10;
  localparam int VERD_W = 2;

  localparam int IT_AW     = $clog2(ITEM_COUNT);
  localparam int TX_AW     = $clog2(TX_COUNT);
  localparam int CLR_COUNT = (ITEM_COUNT > TX_COUNT) ? ITEM_COUNT : TX_COUNT;
  localparam int CLR_AW    = $clog2(CLR_COUNT);

  localparam logic OP_SHARED    = 1'b0;
  localparam logic OP_EXCLUSIVE = 1'b1;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_GRANTED = 2'd0,
    VERDICT_DENIED  = 2'd1,
    VERDICT_IGNORED = 2'd2
  } verdict_e;

  typedef struct packed {
    logic held;
    logic excl;
    logic shared;
  } item_flags_t;

  typedef struct packed {
    item_flags_t       flags;
    logic [TID_W-1:0]  owner;
  } entry_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        flags_we;
    logic        owner_we;
    item_flags_t flags;
    logic        block;
  } decision_t;

endpackage

>>> rtl/core/slt_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_decide
// Lock decision for one request from the entry read out of the tables.
// ----------------------------------------------------------------------------
module slt_decide (
  input  logic                      opcode,
  input  logic [slt_pkg::TID_W-1:0] tid,
  input  slt_pkg::entry_t           entry,
  input  logic                      blocked,
  output slt_pkg::decision_t        dec
);
  import slt_pkg::*;

  logic own;

  assign own = (entry.owner == tid);

  always_comb begin
    dec          = '0;
    dec.verdict  = VERDICT_GRANTED;
    dec.flags    = entry.flags;
    if (blocked) begin
      dec.verdict = VERDICT_IGNORED;
    end else if (opcode == OP_EXCLUSIVE) begin
      if (!entry.flags.held) begin
        dec.flags.held = 1'b1;
        dec.flags.excl = 1'b1;
        dec.flags_we   = 1'b1;
        dec.owner_we   = 1'b1;
      end else if (entry.flags.shared || !own) begin
        dec.block   = 1'b1;
        dec.verdict = VERDICT_DENIED;
      end else begin
        dec.flags.excl = 1'b1;
        dec.flags_we   = 1'b1;
      end
    end else begin
      if (entry.flags.excl) begin
        if (!own) begin
          dec.block   = 1'b1;
          dec.verdict = VERDICT_DENIED;
        end
      end else if (!entry.flags.held) begin
        dec.flags.held = 1'b1;
        dec.flags_we   = 1'b1;
        dec.owner_we   = 1'b1;
      end else if (!own) begin
        dec.flags.shared = 1'b1;
        dec.flags_we     = 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/shared_exclusive_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Shared/exclusive lock manager: per-item lock state and per-transaction
// blocked flags kept in synchronous memories, read-modify-write per request.
//
//   channel  ports                                   transfer
//   input    in_opcode, in_transaction_id, in_item_id start & !busy
//   result   out_verdict                             out_valid (1 cycle)
//
// A request runs as table read, then decide and write back; the verdict is
// registered and shows in the cycle after the decision, when the next
// request can already be taken. After reset a clearing pass over CLR_COUNT
// (1024) entries clears item and blocked flags, one per cycle, busy high.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [slt_pkg::OP_W-1:0]   in_opcode,
  input  logic [slt_pkg::TID_W-1:0]  in_transaction_id,
  input  logic [slt_pkg::ITEM_W-1:0] in_item_id,
  output logic                       out_valid,
  output logic [slt_pkg::VERD_W-1:0] out_verdict
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CLR_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VERD_W-1:0]   out_verdict_r;

  logic                req_opcode_r;
  logic [TID_W-1:0]    req_tid_r;
  logic [IT_AW-1:0]    req_item_r;
  logic [TX_AW-1:0]    req_tx_r;

  item_flags_t         flag_mem [ITEM_COUNT];
  logic [TID_W-1:0]    owner_mem [ITEM_COUNT];
  logic                blk_mem [TX_COUNT];

  item_flags_t         flag_rd_r;
  logic [TID_W-1:0]    owner_rd_r;
  logic                blk_rd_r;

  logic                accept;
  logic                clr_last;
  logic                flag_we, owner_we, blk_we;
  logic [IT_AW-1:0]    flag_waddr;
  item_flags_t         flag_wdata;
  logic [TX_AW-1:0]    blk_waddr;
  logic                blk_wdata;

  entry_t              entry;
  decision_t           dec;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign clr_last = (clr_cnt_r == CLR_AW'(CLR_COUNT - 1));

  assign entry.flags = flag_rd_r;
  assign entry.owner = owner_rd_r;

  slt_decide u_decide (
    .opcode  (req_opcode_r),
    .tid     (req_tid_r),
    .entry   (entry),
    .blocked (blk_rd_r),
    .dec     (dec)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      flag_we    = ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(ITEM_COUNT));
      flag_waddr = clr_cnt_r[IT_AW-1:0];
      flag_wdata = '0;
      owner_we   = 1'b0;
      blk_we     = ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(TX_COUNT));
      blk_waddr  = clr_cnt_r[TX_AW-1:0];
      blk_wdata  = 1'b0;
    end else begin
      flag_we    = (state_r == ST_LOOK) && dec.flags_we;
      flag_waddr = req_item_r;
      flag_wdata = dec.flags;
      owner_we   = (state_r == ST_LOOK) && dec.owner_we;
      blk_we     = (state_r == ST_LOOK) && dec.block;
      blk_waddr  = req_tx_r;
      blk_wdata  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_opcode_r <= in_opcode;
      req_tid_r    <= in_transaction_id;
      req_item_r   <= IT_AW'(in_item_id);
      req_tx_r     <= TX_AW'(in_transaction_id);
    end
    if (state_r == ST_LOOK) begin
      out_verdict_r <= dec.verdict;
    end
  end

  // memory read ports
  always_ff @(posedge clk) begin
    if (accept) begin
      flag_rd_r  <= flag_mem[IT_AW'(in_item_id)];
      owner_rd_r <= owner_mem[IT_AW'(in_item_id)];
      blk_rd_r   <= blk_mem[TX_AW'(in_transaction_id)];
    end
  end

  // memory write ports
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (owner_we) begin
      owner_mem[req_item_r] <= req_tid_r;
    end
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

>>> rtl/core/slt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks for the lock table, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [slt_pkg::VERD_W-1:0] out_verdict
);
  import slt_pkg::*;

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_GRANTED || out_verdict == VERDICT_DENIED ||
                   out_verdict == VERDICT_IGNORED))
    else $error("illegal verdict code");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("verdict missing two cycles after transfer");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("verdict without a request in progress");

endmodule

bind shared_exclusive_lock_table slt_checker u_slt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_verdict (out_verdict)
);

>>> bench/tb_shared_exclusive_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_exclusive_lock_table
// Self-checking bench for the shared/exclusive lock table. A short table of
// directed requests covers free, upgrade, conflict, repeat and blocked cases
// and the field extremes. Random requests on a small, shifting item window
// follow, so that conflicts and denials happen often. Each verdict is checked
// against an in-bench lock model, with sender gaps applied in several phases.
// ----------------------------------------------------------------------------
module tb_shared_exclusive_lock_table;
  import slt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REQ_PER_PHS  = 207;
  localparam int NUM_ROWS     = 24;

  typedef struct packed {
    logic              op;
    logic [TID_W-1:0]  tid;
    logic [ITEM_W-1:0] item;
    logic              chk;
    verdict_e          want;
  } lock_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_opcode = '0;
  logic [TID_W-1:0]   in_transaction_id = '0;
  logic [ITEM_W-1:0]  in_item_id = '0;
  logic               out_valid;
  logic [VERD_W-1:0]  out_verdict;

  // Lock model state
  bit                 lk_held   [ITEM_COUNT];
  bit                 lk_excl   [ITEM_COUNT];
  bit                 lk_shared [ITEM_COUNT];
  logic [TID_W-1:0]   lk_owner  [ITEM_COUNT];
  bit                 tx_blocked[TX_COUNT];

  verdict_e           verdict_queue[$];
  logic               row_chk = 1'b0;
  verdict_e           row_want = VERDICT_GRANTED;
  int                 idle_pct = 0;
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 accepted_count = 0;
  int                 granted_seen = 0;
  int                 denied_seen = 0;
  int                 ignored_seen = 0;
  verdict_e           mon_want;
  verdict_e           mon_got;

  lock_row_t lock_rows [0:NUM_ROWS-1] = '{
    '{OP_SHARED,    8'd0,   10'd0,    1'b1, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd0,   10'd0,    1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd0,   10'd0,    1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd1,   10'd0,    1'b1, VERDICT_DENIED},
    '{OP_EXCLUSIVE, 8'd1,   10'd5,    1'b1, VERDICT_IGNORED},
    '{OP_EXCLUSIVE, 8'd255, 10'd1023, 1'b1, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd255, 10'd1023, 1'b0, VERDICT_GRANTED},
    '{OP_SHARED,    8'd254, 10'd1023, 1'b1, VERDICT_DENIED},
    '{OP_SHARED,    8'd2,   10'd1,    1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd3,   10'd1,    1'b0, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd2,   10'd1,    1'b1, VERDICT_DENIED},
    '{OP_SHARED,    8'd3,   10'd1,    1'b0, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd3,   10'd1,    1'b1, VERDICT_DENIED},
    '{OP_SHARED,    8'd4,   10'd512,  1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd4,   10'd512,  1'b0, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd4,   10'd512,  1'b0, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd5,   10'd512,  1'b1, VERDICT_DENIED},
    '{OP_SHARED,    8'd5,   10'd0,    1'b1, VERDICT_IGNORED},
    '{OP_EXCLUSIVE, 8'd128, 10'd1022, 1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd127, 10'd511,  1'b1, VERDICT_GRANTED},
    '{OP_EXCLUSIVE, 8'd127, 10'd511,  1'b0, VERDICT_GRANTED},
    '{OP_SHARED,    8'd2,   10'd1,    1'b1, VERDICT_IGNORED},
    '{OP_EXCLUSIVE, 8'd170, 10'd682,  1'b1, VERDICT_GRANTED},
    '{OP_SHARED,    8'd85,  10'd341,  1'b1, VERDICT_GRANTED}
  };

  shared_exclusive_lock_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_transaction_id (in_transaction_id),
    .in_item_id        (in_item_id),
    .out_valid         (out_valid),
    .out_verdict       (out_verdict)
  );

  always #5 clk = ~clk;

  // Applies one request to the lock model and returns its verdict.
  function automatic verdict_e lock_decide(input logic op, input logic [TID_W-1:0] tid,
                                           input logic [ITEM_W-1:0] item);
    int tx;
    int it;
    tx = tid % TX_COUNT;
    it = item % ITEM_COUNT;
    if (tx_blocked[tx]) begin
      return VERDICT_IGNORED;
    end
    if (op == OP_EXCLUSIVE) begin
      if (!lk_held[it]) begin
        lk_held[it]  = 1'b1;
        lk_owner[it] = tid;
        lk_excl[it]  = 1'b1;
        return VERDICT_GRANTED;
      end
      if (lk_shared[it] || lk_owner[it] != tid) begin
        tx_blocked[tx] = 1'b1;
        return VERDICT_DENIED;
      end
      lk_excl[it] = 1'b1;
      return VERDICT_GRANTED;
    end
    if (lk_excl[it]) begin
      if (lk_owner[it] == tid) begin
        return VERDICT_GRANTED;
      end
      tx_blocked[tx] = 1'b1;
      return VERDICT_DENIED;
    end
    if (!lk_held[it]) begin
      lk_held[it]  = 1'b1;
      lk_owner[it] = tid;
    end else if (lk_owner[it] != tid) begin
      lk_shared[it] = 1'b1;
    end
    return VERDICT_GRANTED;
  endfunction

  // Returns a transaction that is not yet blocked, or -1 if none is left.
  function automatic int pick_live_tid();
    int t;
    int base;
    for (int i = 0; i < 16; i++) begin
      t = int'($urandom_range(TX_COUNT - 1));
      if (!tx_blocked[t]) begin
        return t;
      end
    end
    base = int'($urandom_range(TX_COUNT - 1));
    for (int i = 0; i < TX_COUNT; i++) begin
      t = (base + i) % TX_COUNT;
      if (!tx_blocked[t]) begin
        return t;
      end
    end
    return -1;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Drives one request after a random gap and returns once it is transferred.
  task automatic send_request(input logic op, input logic [TID_W-1:0] tid,
                              input logic [ITEM_W-1:0] item, input logic chk,
                              input verdict_e want);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start             = 1'b0;
      in_opcode         = OP_W'($urandom_range(1));
      in_transaction_id = TID_W'($urandom_range(TX_COUNT - 1));
      in_item_id        = ITEM_W'($urandom_range(ITEM_COUNT - 1));
    end
    @(negedge clk);
    start             = 1'b1;
    in_opcode         = op;
    in_transaction_id = tid;
    in_item_id        = item;
    row_chk           = chk;
    row_want          = want;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               verdict_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        mon_want = lock_decide(in_opcode, in_transaction_id, in_item_id);
        if (row_chk) begin
          mon_want = row_want;
        end
        verdict_queue.push_back(mon_want);
        accepted_count++;
      end
      if (out_valid) begin
        mon_got = verdict_e'(out_verdict);
        case (mon_got)
          VERDICT_GRANTED: granted_seen++;
          VERDICT_DENIED:  denied_seen++;
          default:         ignored_seen++;
        endcase
        if (verdict_queue.size() == 0) begin
          note_failure($sformatf("verdict %0d with no request pending", out_verdict));
        end else begin
          mon_want = verdict_queue.pop_front();
          if (mon_got !== mon_want) begin
            note_failure($sformatf("verdict expected %s (%0d), got %0d", mon_want.name(),
                                   mon_want, out_verdict));
          end
        end
      end
    end
  end

  initial begin
    int phase_pct [4];
    int tid_pick;
    int pool_base;
    int drain;
    logic op;
    logic [ITEM_W-1:0] item;

    phase_pct = '{0, 61, 0, 7};
    for (int i = 0; i < ITEM_COUNT; i++) begin
      lk_held[i]   = 1'b0;
      lk_excl[i]   = 1'b0;
      lk_shared[i] = 1'b0;
      lk_owner[i]  = '0;
    end
    for (int i = 0; i < TX_COUNT; i++) begin
      tx_blocked[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_request(lock_rows[r].op, lock_rows[r].tid, lock_rows[r].item, lock_rows[r].chk,
                   lock_rows[r].want);
    end

    // the receiver cannot stall, so the phases vary only the sender gaps (0/61/0/7 percent)
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_pct[p];
      pool_base = int'($urandom_range(ITEM_COUNT - 16));
      for (int n = 0; n < REQ_PER_PHS; n++) begin
        tid_pick = -1;
        if ($urandom_range(99) < 80) begin
          tid_pick = pick_live_tid();
        end
        if (tid_pick < 0) begin
          tid_pick = int'($urandom_range(TX_COUNT - 1));
        end
        if (n % 40 == 39) begin
          pool_base = int'($urandom_range(ITEM_COUNT - 16));
        end
        if ($urandom_range(99) < 55) begin
          item = ITEM_W'(pool_base + int'($urandom_range(15)));
        end else begin
          item = ITEM_W'($urandom_range(ITEM_COUNT - 1));
        end
        op = ($urandom_range(99) < 45) ? OP_EXCLUSIVE : OP_SHARED;
        send_request(op, TID_W'(tid_pick), item, 1'b0, VERDICT_GRANTED);
      end
    end

    @(negedge clk);
    start = 1'b0;
    drain = 0;
    while (verdict_queue.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (verdict_queue.size() != 0) begin
      note_failure($sformatf("%0d verdicts never arrived", verdict_queue.size()));
    end

    $display("transferred %0d lock requests: %0d granted, %0d denied, %0d ignored",
             accepted_count, granted_seen, denied_seen, ignored_seen);
    $display("sender gap phases 0/61/0/7 percent, %0d failures", fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
